// ----- rtl/programmable_fsm_reachability_unit_defines.svh -----
// assertion macros for the programmable fsm reachability unit
// used by the port checker; no other dependencies
`ifndef PROGRAMMABLE_FSM_REACHABILITY_UNIT_DEFINES_SVH
`define PROGRAMMABLE_FSM_REACHABILITY_UNIT_DEFINES_SVH

// same-cycle implication under synchronous reset
`define PFR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define PFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pfr_pkg.sv -----
// shared types, constants and reset edge table of the fsm reachability unit
// no dependencies
`timescale 1ns / 1ps

package pfr_pkg;

   // machine size and derived widths
   localparam int NumStates = 8;
   localparam int StateW    = $clog2(NumStates);
   localparam int LevelW    = $clog2(NumStates);
   localparam int CountW    = ($clog2(NumStates + 1) > 4) ? $clog2(NumStates + 1) : 4;
   localparam int MaskW     = 8;
   localparam int RspCountW = 4;
   localparam int RspStateW = 3;
   localparam int MaxCount  = 15;

   // request codes
   typedef enum logic [1:0] {
      REQ_STEP  = 2'd0,
      REQ_SET   = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_DONE
   } fsm_state_type;

   // edge rewrite command handed to one cell
   typedef struct packed {
      logic              en;
      logic              edge_bit;
      logic [StateW-1:0] target;
   } edge_wr_type;

   // reset destination of the zero edge of state idx
   function automatic logic [StateW-1:0] reset_zero(input logic [StateW-1:0] idx);
      logic [2:0] base;
      int         dest;
      base = 3'(idx);
      case (base)
         3'd0: dest = 7;
         3'd1: dest = 2;
         3'd2: dest = 4;
         3'd3: dest = 5;
         3'd4: dest = 0;
         3'd5: dest = 6;
         3'd6: dest = 1;
         3'd7: dest = 3;
         default: dest = 0;
      endcase
      return StateW'(dest % NumStates);
   endfunction

   // reset destination of the one edge of state idx
   function automatic logic [StateW-1:0] reset_one(input logic [StateW-1:0] idx);
      logic [2:0] base;
      int         dest;
      base = 3'(idx);
      case (base)
         3'd0: dest = 2;
         3'd1: dest = 0;
         3'd2: dest = 5;
         3'd3: dest = 7;
         3'd4: dest = 3;
         3'd5: dest = 4;
         3'd6: dest = 6;
         3'd7: dest = 6;
         default: dest = 0;
      endcase
      return StateW'(dest % NumStates);
   endfunction

endpackage

// ----- rtl/pfr_channels.sv -----
// valid/ready channel interfaces for requests and responses
// depends on nothing but fixed field widths
`timescale 1ns / 1ps

interface pfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       edge_bit;
   logic [2:0] target_state;

   modport source (output valid, req_type, edge_bit, target_state, input ready);
   modport sink   (input valid, req_type, edge_bit, target_state, output ready);
endinterface

interface pfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] current_state;
   logic [7:0] unreachable_mask;
   logic [3:0] unreachable_count;

   modport source (output valid, current_state, unreachable_mask, unreachable_count,
                   input ready);
   modport sink   (input valid, current_state, unreachable_mask, unreachable_count,
                   output ready);
endinterface

// ----- rtl/pfr_cell.sv -----
// one state cell: holds the two outgoing edges of its state and adds its
// successors to the reach vector passed along the chain; uses pfr_pkg
`timescale 1ns / 1ps

module pfr_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pfr_pkg::StateW-1:0]         cell_idx,
   input  pfr_pkg::edge_wr_type               wr,
   input  logic                               reached,
   input  logic [pfr_pkg::NumStates-1:0]      grow_in,
   output logic [pfr_pkg::NumStates-1:0]      grow_out,
   output logic [pfr_pkg::StateW-1:0]         next_zero,
   output logic [pfr_pkg::StateW-1:0]         next_one
);

   logic [pfr_pkg::StateW-1:0] zero_ff, zero_in;
   logic [pfr_pkg::StateW-1:0] one_ff, one_in;

   // edge rewrite
   always_comb begin
      zero_in = zero_ff;
      one_in  = one_ff;
      if (wr.en) begin
         if (wr.edge_bit) begin
            one_in = wr.target;
         end else begin
            zero_in = wr.target;
         end
      end
   end

   // edge registers, loaded with the start graph on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= pfr_pkg::reset_zero(cell_idx);
         one_ff  <= pfr_pkg::reset_one(cell_idx);
      end else begin
         zero_ff <= zero_in;
         one_ff  <= one_in;
      end
   end

   // successors of a reached state join the passing vector
   always_comb begin
      grow_out = grow_in;
      if (reached) begin
         grow_out = grow_in
                  | (pfr_pkg::NumStates'(1) << zero_ff)
                  | (pfr_pkg::NumStates'(1) << one_ff);
      end
   end

   assign next_zero = zero_ff;
   assign next_one  = one_ff;

endmodule

// ----- rtl/programmable_fsm_reachability_unit.sv -----
// top level of the programmable fsm reachability unit: controller, response
// register and the chain of state cells; uses pfr_pkg, pfr_channels, pfr_cell
`timescale 1ns / 1ps

// An 8-state machine whose transition table can be rewritten at run time.
// Each state lives in one cell of a chain; a cell holds the state's zero and
// one edges. A step or an edge rewrite is answered in the cycle after it is
// accepted. A query seeds the reached set with the present state when it is
// accepted; then, in ST_EXPAND, the reached set grows level by level as the
// reach vector ripples through the cell chain, and ST_DONE forms the
// unreachable mask and count. Requests are taken one at a time; the response
// sits in an output register, and the next request is taken no earlier than
// the cycle in which that response leaves on rsp_chan.ready, so a stalled
// receiver also holds off the request side. No configuration, no clearing
// pass after reset.
module programmable_fsm_reachability_unit (
   input  logic      clock,
   input  logic      reset,
   pfr_req_if.sink   req_chan,
   pfr_rsp_if.source rsp_chan
);

   localparam int N = pfr_pkg::NumStates;

   pfr_pkg::fsm_state_type            state_ff, state_in;
   logic [pfr_pkg::LevelW-1:0]        level_ff, level_in;
   logic [pfr_pkg::StateW-1:0]        present_ff, present_in;
   logic [N-1:0]                      reached_ff, reached_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pfr_pkg::RspStateW-1:0]     rsp_cur_ff, rsp_cur_in;
   logic [pfr_pkg::MaskW-1:0]         rsp_mask_ff, rsp_mask_in;
   logic [pfr_pkg::RspCountW-1:0]     rsp_count_ff, rsp_count_in;

   logic                              slot_free;
   logic                              accept;
   pfr_pkg::req_kind_type             kind;
   pfr_pkg::edge_wr_type              wr_cmd;
   pfr_pkg::edge_wr_type              cell_wr [N];
   logic [N-1:0]                      grow [N+1];
   logic [pfr_pkg::StateW-1:0]        cell_zero [N];
   logic [pfr_pkg::StateW-1:0]        cell_one [N];
   logic [pfr_pkg::StateW-1:0]        step_next;
   logic [N-1:0]                      unreached;
   logic [pfr_pkg::MaskW-1:0]         unreached_mask;
   logic [pfr_pkg::CountW-1:0]        unreached_cnt;
   logic [pfr_pkg::RspCountW-1:0]     unreached_sat;

   // request handshake
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == pfr_pkg::ST_IDLE) && slot_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign kind           = pfr_pkg::req_kind_type'(req_chan.req_type);

   // edge rewrite command, ignored for targets beyond the machine
   always_comb begin
      wr_cmd.en       = accept && (kind == pfr_pkg::REQ_SET)
                        && (32'(req_chan.target_state) < 32'(N));
      wr_cmd.edge_bit = req_chan.edge_bit;
      wr_cmd.target   = pfr_pkg::StateW'(req_chan.target_state);
   end

   // chain of state cells
   assign grow[0] = '0;
   for (genvar g = 0; g < N; g++) begin : g_cell
      always_comb begin
         cell_wr[g]    = wr_cmd;
         cell_wr[g].en = wr_cmd.en && (present_ff == pfr_pkg::StateW'(g));
      end

      pfr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (pfr_pkg::StateW'(g)),
         .wr        (cell_wr[g]),
         .reached   (reached_ff[g]),
         .grow_in   (grow[g]),
         .grow_out  (grow[g+1]),
         .next_zero (cell_zero[g]),
         .next_one  (cell_one[g])
      );
   end

   // successor of the present state for a step
   assign step_next = req_chan.edge_bit ? cell_one[present_ff] : cell_zero[present_ff];

   // unreachable mask and saturated count of the finished reached set
   always_comb begin
      unreached      = ~reached_ff;
      unreached_mask = '0;
      unreached_cnt  = '0;
      for (int i = 0; i < pfr_pkg::MaskW; i++) begin
         if (i < N) begin
            unreached_mask[i] = unreached[i];
         end
      end
      for (int i = 0; i < N; i++) begin
         unreached_cnt = unreached_cnt + pfr_pkg::CountW'(unreached[i]);
      end
      if (unreached_cnt > pfr_pkg::CountW'(pfr_pkg::MaxCount)) begin
         unreached_sat = pfr_pkg::RspCountW'(pfr_pkg::MaxCount);
      end else begin
         unreached_sat = pfr_pkg::RspCountW'(unreached_cnt);
      end
   end

   // controller next state and response register loading
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      present_in   = present_ff;
      reached_in   = reached_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_cur_in   = rsp_cur_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         pfr_pkg::ST_IDLE: begin
            if (accept) begin
               case (kind)
                  pfr_pkg::REQ_STEP: begin
                     present_in   = step_next;
                     rsp_valid_in = 1'b1;
                     rsp_cur_in   = pfr_pkg::RspStateW'(step_next);
                     rsp_mask_in  = '0;
                     rsp_count_in = '0;
                  end
                  pfr_pkg::REQ_QUERY: begin
                     reached_in = N'(1) << present_ff;
                     level_in   = '0;
                     state_in   = pfr_pkg::ST_EXPAND;
                  end
                  default: begin
                     // rewrite and unused codes answer with the present state
                     rsp_valid_in = 1'b1;
                     rsp_cur_in   = pfr_pkg::RspStateW'(present_ff);
                     rsp_mask_in  = '0;
                     rsp_count_in = '0;
                  end
               endcase
            end
         end
         pfr_pkg::ST_EXPAND: begin
            // one reach level per cycle through the chain
            reached_in = reached_ff | grow[N];
            level_in   = level_ff + 1'b1;
            if (level_ff == pfr_pkg::LevelW'(N - 1)) begin
               state_in = pfr_pkg::ST_DONE;
            end
         end
         pfr_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in   = pfr_pkg::RspStateW'(present_ff);
               rsp_mask_in  = unreached_mask;
               rsp_count_in = unreached_sat;
               state_in     = pfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfr_pkg::ST_IDLE;
         level_ff     <= '0;
         present_ff   <= pfr_pkg::StateW'(1 % N);
         reached_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         present_ff   <= present_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_cur_ff   <= rsp_cur_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.current_state     = rsp_cur_ff;
   assign rsp_chan.unreachable_mask  = rsp_mask_ff;
   assign rsp_chan.unreachable_count = rsp_count_ff;

endmodule

// ----- rtl/pfr_checker.sv -----
// port-level checks of the fsm reachability unit's response channel
// depends on programmable_fsm_reachability_unit_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "programmable_fsm_reachability_unit_defines.svh"

module pfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] current_state,
   input logic [7:0] unreachable_mask,
   input logic [3:0] unreachable_count
);

   // a stalled response stays offered
   `PFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // count agrees with the mask
   `PFR_ASSERT_IMPLY(a_count_mask, clock, reset, rsp_valid, $countones(unreachable_mask) == unreachable_count, "count does not match mask")

   // the present state is always reached
   `PFR_ASSERT_IMPLY(a_present_reached, clock, reset, rsp_valid, !unreachable_mask[current_state], "present state marked unreachable")

   // a query never reports every state as unreachable
   `PFR_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, unreachable_count != 4'd8, "all states reported unreachable")

endmodule

bind programmable_fsm_reachability_unit pfr_checker u_pfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .current_state     (rsp_chan.current_state),
   .unreachable_mask  (rsp_chan.unreachable_mask),
   .unreachable_count (rsp_chan.unreachable_count)
);
